>>> rtl/tbq_pkg.sv
`default_nettype none

package tbq_pkg;

    // Widths and counts
    localparam int ADC_BITS    = 10;
    localparam int NUM_BUTTONS = 5;
    localparam int MAX_SLOTS   = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 10;
    localparam int HALF_W      = 9;
    localparam int COUNT_W     = 4;
    localparam int VOL_W       = 7;
    localparam int BASS_W      = 4;
    localparam int HIT_W       = 3;
    // Signed width that holds a button centre plus or minus a half size
    localparam int COORD_W     = ADC_BITS + 3;

    // Button X centres; slots past the fifth sit at zero
    localparam int BTN_CX [MAX_SLOTS] = '{150, 300, 450, 610, 770, 0, 0};

    // Button codes
    localparam logic [HIT_W-1:0] BTN_SEL_VOLUME = 3'd0;
    localparam logic [HIT_W-1:0] BTN_SEL_BASS   = 3'd1;
    localparam logic [HIT_W-1:0] BTN_IDLE       = 3'd2;
    localparam logic [HIT_W-1:0] BTN_UP         = 3'd3;
    localparam logic [HIT_W-1:0] BTN_DOWN       = 3'd4;
    localparam logic [HIT_W-1:0] NO_BUTTON      = 3'd5;

    // Level limits and reset values
    localparam logic [VOL_W-1:0]  VOL_MAX    = 7'd64;
    localparam logic [VOL_W-1:0]  VOL_RESET  = 7'd32;
    localparam logic [BASS_W-1:0] BASS_MAX   = 4'h0F;
    localparam logic [BASS_W-1:0] BASS_RESET = 4'd5;

    // Configuration reset values
    localparam logic [ADC_BITS-1:0] X_PRESS_MIN_RESET = 10'd50;
    localparam logic [ADC_BITS-1:0] Y_PRESS_MIN_RESET = 10'd100;
    localparam logic [ADC_BITS-1:0] X_WINDOW_RESET    = 10'd30;
    localparam logic [ADC_BITS-1:0] Y_WINDOW_RESET    = 10'd20;
    localparam logic [COUNT_W-1:0]  CONFIRM_RESET     = 4'd3;
    localparam logic [HALF_W-1:0]   HALF_WIDTH_RESET  = 9'd50;
    localparam logic [HALF_W-1:0]   HALF_HEIGHT_RESET = 9'd30;
    localparam logic [ADC_BITS-1:0] ROW_Y_RESET       = 10'd720;

    typedef enum logic [1:0] {
        ITEM_SONG   = 2'd0,
        ITEM_VOLUME = 2'd1,
        ITEM_BASS   = 2'd2
    } item_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_PRESS_MIN = 3'd0,
        CFG_Y_PRESS_MIN = 3'd1,
        CFG_X_WINDOW    = 3'd2,
        CFG_Y_WINDOW    = 3'd3,
        CFG_CONFIRM     = 3'd4,
        CFG_HALF_WIDTH  = 3'd5,
        CFG_HALF_HEIGHT = 3'd6,
        CFG_ROW_Y       = 3'd7
    } cfg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [ADC_BITS-1:0] x_press_min;
        logic [ADC_BITS-1:0] y_press_min;
        logic [ADC_BITS-1:0] x_window;
        logic [ADC_BITS-1:0] y_window;
        logic [COUNT_W-1:0]  confirm_count;
        logic [HALF_W-1:0]   button_half_width;
        logic [HALF_W-1:0]   button_half_height;
        logic [ADC_BITS-1:0] button_row_y;
    } cfg_t;

    typedef struct packed {
        logic [ADC_BITS-1:0] prev_x;
        logic [ADC_BITS-1:0] prev_y;
        logic [COUNT_W-1:0]  match_count;
        item_t               item_select;
        logic [VOL_W-1:0]    volume;
        logic [BASS_W-1:0]   bass;
    } state_t;

    typedef struct packed {
        logic                press_confirmed;
        logic [HIT_W-1:0]    button_hit;
        logic [1:0]          selected_item;
        logic [VOL_W-1:0]    volume_level;
        logic [BASS_W-1:0]   bass_level;
        logic                settings_changed;
        logic                skip_track;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/tbq_channels.sv
`default_nettype none

// Touch sample channel
interface tbq_sample_if;
    logic                         valid;
    logic                         ready;
    logic [tbq_pkg::ADC_BITS-1:0] touch_x;
    logic [tbq_pkg::ADC_BITS-1:0] touch_y;

    modport source (output valid, output touch_x, output touch_y, input ready);
    modport sink   (input valid, input touch_x, input touch_y, output ready);
endinterface

// Result channel
interface tbq_result_if;
    logic                           valid;
    logic                           ready;
    logic                           press_confirmed;
    logic [tbq_pkg::HIT_W-1:0]      button_hit;
    logic [1:0]                     selected_item;
    logic [tbq_pkg::VOL_W-1:0]      volume_level;
    logic [tbq_pkg::BASS_W-1:0]     bass_level;
    logic                           settings_changed;
    logic                           skip_track;

    modport source (output valid, output press_confirmed, output button_hit,
                    output selected_item, output volume_level, output bass_level,
                    output settings_changed, output skip_track, input ready);
    modport sink   (input valid, input press_confirmed, input button_hit,
                    input selected_item, input volume_level, input bass_level,
                    input settings_changed, input skip_track, output ready);
endinterface

// Configuration write channel
interface tbq_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tbq_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [tbq_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

>>> rtl/touch_button_qualifier_core.sv
`default_nettype none

// Channel   Dir  Payload                                      Handshake
// sample    in   touch_x, touch_y                             valid/ready
// result    out  press_confirmed, button_hit, selected_item,  valid/ready
//                volume_level, bass_level, settings_changed,
//                skip_track
// cfg       in   reg_index, wdata                             valid/ready (always ready)
//
// One sample per clock while result is not stalled; each sample is registered
// in the input register, then in the result register. The rate is set by the
// single pass through qualify and hit-test logic between those two registers.
// A stalled result holds while the input register keeps taking one more sample.
// Reset restores the configuration defaults, volume 32, bass 5, song selected.
module touch_button_qualifier_core (
    input  wire logic clk,
    input  wire logic rst_n,
    tbq_sample_if.sink   sample,
    tbq_result_if.source result,
    tbq_cfg_if.sink      cfg
);
    import tbq_pkg::*;

    cfg_t    cfg_cur;
    state_t  state_reg;
    state_t  state_next;
    result_t step_result;
    result_t result_reg;
    logic [HIT_W-1:0] hit;

    logic                s1_valid_reg;
    logic [ADC_BITS-1:0] s1_x_reg;
    logic [ADC_BITS-1:0] s1_y_reg;
    logic                out_valid_reg;
    logic                advance;

    tbq_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    tbq_hit_test u_hit (
        .x      (s1_x_reg),
        .y      (s1_y_reg),
        .cfg_in (cfg_cur),
        .hit    (hit)
    );

    tbq_step u_step (
        .x         (s1_x_reg),
        .y         (s1_y_reg),
        .cfg_in    (cfg_cur),
        .state_in  (state_reg),
        .hit       (hit),
        .state_out (state_next),
        .result    (step_result)
    );

    // Move the held sample into the result register when it is free
    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
                s1_valid_reg <= sample.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture the sample
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_x_reg <= sample.touch_x;
            s1_y_reg <= sample.touch_y;
        end
    end

    // Advance the qualifier state once per processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prev_x      <= '0;
            state_reg.prev_y      <= '0;
            state_reg.match_count <= '0;
            state_reg.item_select <= ITEM_SONG;
            state_reg.volume      <= VOL_RESET;
            state_reg.bass        <= BASS_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Register the result
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= step_result;
    end

    assign result.valid            = out_valid_reg;
    assign result.press_confirmed  = result_reg.press_confirmed;
    assign result.button_hit       = result_reg.button_hit;
    assign result.selected_item    = result_reg.selected_item;
    assign result.volume_level     = result_reg.volume_level;
    assign result.bass_level       = result_reg.bass_level;
    assign result.settings_changed = result_reg.settings_changed;
    assign result.skip_track       = result_reg.skip_track;

endmodule

`default_nettype wire

>>> rtl/tbq_cfg_regs.sv
`default_nettype none

module tbq_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tbq_cfg_if.sink      cfg,
    output tbq_pkg::cfg_t cfg_out
);
    import tbq_pkg::*;

    cfg_t cfg_reg;

    // Take every write request at once
    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    // Decode the index and update one field
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_press_min        <= X_PRESS_MIN_RESET;
            cfg_reg.y_press_min        <= Y_PRESS_MIN_RESET;
            cfg_reg.x_window           <= X_WINDOW_RESET;
            cfg_reg.y_window           <= Y_WINDOW_RESET;
            cfg_reg.confirm_count      <= CONFIRM_RESET;
            cfg_reg.button_half_width  <= HALF_WIDTH_RESET;
            cfg_reg.button_half_height <= HALF_HEIGHT_RESET;
            cfg_reg.button_row_y       <= ROW_Y_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.reg_index))
                CFG_X_PRESS_MIN: cfg_reg.x_press_min   <= cfg.wdata;
                CFG_Y_PRESS_MIN: cfg_reg.y_press_min   <= cfg.wdata;
                CFG_X_WINDOW:    cfg_reg.x_window      <= cfg.wdata;
                CFG_Y_WINDOW:    cfg_reg.y_window      <= cfg.wdata;
                CFG_CONFIRM:     cfg_reg.confirm_count <= cfg.wdata[COUNT_W-1:0];
                CFG_HALF_WIDTH:  cfg_reg.button_half_width  <= cfg.wdata[HALF_W-1:0];
                CFG_HALF_HEIGHT: cfg_reg.button_half_height <= cfg.wdata[HALF_W-1:0];
                CFG_ROW_Y:       cfg_reg.button_row_y  <= cfg.wdata;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/tbq_hit_test.sv
`default_nettype none

module tbq_hit_test (
    input  wire logic [tbq_pkg::ADC_BITS-1:0] x,
    input  wire logic [tbq_pkg::ADC_BITS-1:0] y,
    input  wire tbq_pkg::cfg_t                cfg_in,
    output logic      [tbq_pkg::HIT_W-1:0]    hit
);
    import tbq_pkg::*;

    coord_t sx;
    coord_t sy;
    coord_t hw;
    coord_t hh;
    coord_t ry;
    logic   row_ok;
    logic [HIT_W-1:0] hit_raw;

    // Widen everything to signed coordinates
    assign sx = coord_t'({3'b000, x});
    assign sy = coord_t'({3'b000, y});
    assign hw = coord_t'({4'b0000, cfg_in.button_half_width});
    assign hh = coord_t'({4'b0000, cfg_in.button_half_height});
    assign ry = coord_t'({3'b000, cfg_in.button_row_y});

    assign row_ok = (sy > ry - hh) && (sy < ry + hh);

    // Scan the row; the highest matching button wins
    always_comb
    begin
        hit_raw = NO_BUTTON;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (row_ok && (sx > coord_t'(BTN_CX[i]) - hw) &&
                (sx < coord_t'(BTN_CX[i]) + hw))
            begin
                hit_raw = HIT_W'(i);
            end
        end
    end

    // Report slots past the last real button as no button
    assign hit = (hit_raw > BTN_DOWN) ? NO_BUTTON : hit_raw;

endmodule

`default_nettype wire

>>> rtl/tbq_step.sv
`default_nettype none

module tbq_step (
    input  wire logic [tbq_pkg::ADC_BITS-1:0] x,
    input  wire logic [tbq_pkg::ADC_BITS-1:0] y,
    input  wire tbq_pkg::cfg_t                cfg_in,
    input  wire tbq_pkg::state_t              state_in,
    input  wire logic [tbq_pkg::HIT_W-1:0]    hit,
    output tbq_pkg::state_t                   state_out,
    output tbq_pkg::result_t                  result
);
    import tbq_pkg::*;

    logic                touched;
    logic [ADC_BITS-1:0] dx;
    logic [ADC_BITS-1:0] dy;
    logic                close;
    logic [COUNT_W-1:0]  count_inc;

    assign touched   = (x > cfg_in.x_press_min) && (y > cfg_in.y_press_min);
    assign dx        = (x > state_in.prev_x) ? x - state_in.prev_x : state_in.prev_x - x;
    assign dy        = (y > state_in.prev_y) ? y - state_in.prev_y : state_in.prev_y - y;
    assign close     = (dx < cfg_in.x_window) && (dy < cfg_in.y_window);
    assign count_inc = state_in.match_count + COUNT_W'(1);

    // Qualify the sample, then act on a confirmed press
    always_comb
    begin
        state_out                 = state_in;
        result.press_confirmed    = 1'b0;
        result.button_hit         = NO_BUTTON;
        result.settings_changed   = 1'b0;
        result.skip_track         = 1'b0;

        if (touched)
        begin
            state_out.prev_x = x;
            state_out.prev_y = y;
            if (!close)
            begin
                state_out.match_count = '0;
            end
            else if (count_inc < cfg_in.confirm_count)
            begin
                state_out.match_count = count_inc;
            end
            else
            begin
                state_out.match_count  = '0;
                result.press_confirmed = 1'b1;
                result.button_hit      = hit;
                case (hit)
                    BTN_SEL_VOLUME: state_out.item_select = ITEM_VOLUME;
                    BTN_SEL_BASS:   state_out.item_select = ITEM_BASS;
                    BTN_IDLE:       ;
                    BTN_UP:
                    begin
                        case (state_in.item_select)
                            ITEM_SONG: result.skip_track = 1'b1;
                            ITEM_VOLUME:
                            begin
                                if (state_in.volume != '0)
                                    state_out.volume = state_in.volume - VOL_W'(1);
                                result.settings_changed = 1'b1;
                            end
                            ITEM_BASS:
                            begin
                                if (state_in.bass < BASS_MAX)
                                    state_out.bass = state_in.bass + BASS_W'(1);
                                result.settings_changed = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                    BTN_DOWN:
                    begin
                        case (state_in.item_select)
                            ITEM_VOLUME:
                            begin
                                if (state_in.volume < VOL_MAX)
                                    state_out.volume = state_in.volume + VOL_W'(1);
                            end
                            ITEM_BASS:
                            begin
                                if (state_in.bass != '0)
                                    state_out.bass = state_in.bass - BASS_W'(1);
                            end
                            default: ;
                        endcase
                        result.settings_changed = 1'b1;
                    end
                    default: state_out.item_select = ITEM_SONG;
                endcase
            end
        end

        result.selected_item = state_out.item_select;
        result.volume_level  = state_out.volume;
        result.bass_level    = state_out.bass;
    end

endmodule

`default_nettype wire
